// File: rtl/jfk_pkg.sv
// Shared types, constants and helper functions for the joint forward-kinematics block.
// Used by jfk_front, jfk_back and joint_forward_kinematics; depends on nothing.
package jfk_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int JOINT_COUNT = 6;
   localparam int ANGLE_MIN   = -180;
   localparam int ANGLE_MAX   = 180;
   localparam int QUARTER     = 90;
   localparam int HALF        = 180;

   localparam int JN_W    = 3;               // joint number field
   localparam int JA_W    = 10;              // joint angle field
   localparam int JIDX_W  = 3;               // index into the stored joint angles
   localparam int ANG_W   = 9;               // stored angle
   localparam int SIN_W   = FRAC_BITS + 1;   // unsigned table entry, holds 1.0
   localparam int ROT_W   = FRAC_BITS + 4;   // rotation element
   localparam int TR_W    = 40;              // translation element
   localparam int DATA_W  = 32;              // registers and output elements
   localparam int MUL_W   = ROT_W + DATA_W;
   localparam int ACC_W   = MUL_W + 1;
   localparam int Q_DEPTH = 2;

   localparam logic [1:0] ROW_LAST = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_JOINT = 2'd1,
      ST_BAD_ANGLE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BASE     = 2'd0,
      REG_SHOULDER = 2'd1,
      REG_ELBOW    = 2'd2,
      REG_TOOL     = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIG,
      S_INIT,
      S_MUL,
      S_OUT
   } state_type;

   typedef struct packed {
      status_type                status;
      logic [JIDX_W-1:0]         joint;
      logic signed [ANG_W-1:0]   angle;
   } qent_type;

   // Sine of d whole degrees (0..90), evaluated at elaboration only.
   function automatic logic [SIN_W-1:0] sin_calc(input int d);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s30;
      logic [63:0] r;
      x  = 64'(d) * 64'd18740330;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 7; k >= 1; k--) begin
         t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1)));
      end
      s30 = (x * t) >> 30;
      r   = (s30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return r[SIN_W-1:0];
   endfunction

   // Drop the fraction bits, rounding half away from zero.
   function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] h;
      logic signed [ACC_W-1:0] r;
      h = '0;
      h[FRAC_BITS-1] = 1'b1;
      if (!p[ACC_W-1]) begin
         r = (p + h) >>> FRAC_BITS;
      end else begin
         r = -((-p + h) >>> FRAC_BITS);
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] sat32(input logic signed [TR_W-1:0] v);
      logic [DATA_W-1:0] r;
      if ((&v[TR_W-1:DATA_W-1]) || !(|v[TR_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[TR_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/jfk_front.sv
// Front end: accepts joint updates, checks joint number and angle range,
// and queues the classified item for the back end. Depends on jfk_pkg.
module jfk_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [jfk_pkg::JN_W-1:0]    req_joint_number,
   input  logic signed [jfk_pkg::JA_W-1:0] req_joint_angle,
   output logic                        q_valid,
   output jfk_pkg::qent_type           q_entry,
   input  logic                        q_pop
);
   import jfk_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ff;
   logic       rd_ff;
   qent_type   ent_ff [Q_DEPTH];
   qent_type   ent_new;
   logic       push;

   assign req_ready = (count_ff < 2'(Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = ent_ff[rd_ff];

   // Joint check takes precedence over the angle check.
   always_comb begin
      ent_new.joint = JIDX_W'(req_joint_number - 3'd1);
      ent_new.angle = req_joint_angle[ANG_W-1:0];
      priority if (req_joint_number == '0 || req_joint_number > JOINT_COUNT) begin
         ent_new.status = ST_BAD_JOINT;
      end else if (req_joint_angle < ANGLE_MIN || req_joint_angle > ANGLE_MAX) begin
         ent_new.status = ST_BAD_ANGLE;
      end else begin
         ent_new.status = ST_OK;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (q_pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= ent_new;
      end
   end

endmodule

// File: rtl/jfk_back.sv
// Back end: holds joint angles and offsets, runs the sine lookup and the
// matrix chain on one shared multiplier, and drives the result register. Depends on jfk_pkg.
module jfk_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  jfk_pkg::qent_type            q_entry,
   output logic                         q_pop,
   input  logic                         csr_write_en,
   input  logic [1:0]                   csr_index,
   input  logic [jfk_pkg::DATA_W-1:0]   csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [1:0]                   rsp_row_index,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col0,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col1,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col2,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col3,
   output logic                         rsp_last_row
);
   import jfk_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] jcnt_ff, jcnt_in;
   logic [1:0] row_ff, row_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic signed [ANG_W-1:0]  joint_ff [JOINT_COUNT];
   logic signed [DATA_W-1:0] off_ff [4];
   logic signed [SIN_W:0]    sin_ff [4];
   logic signed [SIN_W:0]    cos_ff [4];
   logic signed [ROT_W-1:0]  p_rot_ff [3][3];
   logic signed [TR_W-1:0]   p_tr_ff [3];
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ROT_W-1:0]  r0_ff, r2_ff;

   logic [1:0]               status_ff;
   logic [1:0]               row_idx_ff;
   logic [DATA_W-1:0]        col_ff [4];
   logic                     last_ff;

   logic load_out, load_err, trig_we, init_we, row_we, joint_we;

   // ---- sine table ----
   logic [SIN_W-1:0] sin_rom [QUARTER+1];
   for (genvar gd = 0; gd <= QUARTER; gd++) begin : g_sin
      localparam logic [SIN_W-1:0] V = sin_calc(gd);
      assign sin_rom[gd] = V;
   end

   // ---- trig of joint jcnt (joint four negated) ----
   logic signed [ANG_W:0]   ta, tmag;
   logic [7:0]              tm;
   logic                    tneg, cneg;
   logic [6:0]              si, ci;
   logic signed [SIN_W:0]   s_mag, c_mag, s_val, c_val;

   always_comb begin
      ta = {joint_ff[JIDX_W'(jcnt_ff)][ANG_W-1], joint_ff[JIDX_W'(jcnt_ff)]};
      if (jcnt_ff == 2'd3) begin
         ta = -ta;
      end
      tneg = ta[ANG_W];
      tmag = tneg ? -ta : ta;
      tm   = tmag[7:0];
      if (tm <= 8'(QUARTER)) begin
         si   = 7'(tm);
         ci   = 7'(8'(QUARTER) - tm);
         cneg = 1'b0;
      end else begin
         si   = 7'(8'(HALF) - tm);
         ci   = 7'(tm - 8'(QUARTER));
         cneg = 1'b1;
      end
      s_mag = {1'b0, sin_rom[si]};
      c_mag = {1'b0, sin_rom[ci]};
      s_val = tneg ? -s_mag : s_mag;
      c_val = cneg ? -c_mag : c_mag;
   end

   // ---- shared multiply-accumulate ----
   logic signed [ROT_W-1:0]  a0, a1, a2, mul_a;
   logic signed [TR_W-1:0]   a3;
   logic signed [SIN_W:0]    cs, sn, sn_neg;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [MUL_W-1:0]  prod;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [TR_W-1:0]   tr_new;

   assign a0     = p_rot_ff[row_ff][0];
   assign a1     = p_rot_ff[row_ff][1];
   assign a2     = p_rot_ff[row_ff][2];
   assign a3     = p_tr_ff[row_ff];
   assign cs     = cos_ff[jcnt_ff];
   assign sn     = sin_ff[jcnt_ff];
   assign sn_neg = -sn;

   always_comb begin
      unique case (step_ff)
         3'd0:    begin mul_a = a0; mul_b = DATA_W'(cs);     end
         3'd1:    begin mul_a = a2; mul_b = DATA_W'(sn_neg); end
         3'd2:    begin mul_a = a0; mul_b = DATA_W'(sn);     end
         3'd3:    begin mul_a = a2; mul_b = DATA_W'(cs);     end
         3'd4:    begin mul_a = a0; mul_b = off_ff[jcnt_ff]; end
         default: begin mul_a = a0; mul_b = '0;              end
      endcase
      prod = MUL_W'(mul_a) * MUL_W'(mul_b);
      if (step_ff == 3'd1 || step_ff == 3'd3) begin
         acc_in = acc_ff + ACC_W'(prod);
      end else begin
         acc_in = ACC_W'(prod);
      end
      rnd    = round_frac(acc_ff);
      tr_new = rnd[TR_W-1:0] + a3;
   end

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      jcnt_in      = jcnt_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      load_out     = 1'b0;
      load_err     = 1'b0;
      trig_we      = 1'b0;
      init_we      = 1'b0;
      row_we       = 1'b0;
      joint_we     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_ready)) begin
               q_pop = 1'b1;
               if (q_entry.status != ST_OK) begin
                  load_err = 1'b1;
               end else begin
                  joint_we = 1'b1;
                  jcnt_in  = 2'd0;
                  state_in = S_TRIG;
               end
            end
         end
         S_TRIG: begin
            trig_we = 1'b1;
            jcnt_in = jcnt_ff + 2'd1;
            if (jcnt_ff == 2'd3) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            init_we  = 1'b1;
            jcnt_in  = 2'd1;
            row_in   = 2'd0;
            step_in  = 3'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (step_ff == 3'd5) begin
               row_we  = 1'b1;
               step_in = 3'd0;
               row_in  = row_ff + 2'd1;
               if (row_ff == ROW_LAST) begin
                  row_in  = 2'd0;
                  jcnt_in = jcnt_ff + 2'd1;
                  if (jcnt_ff == 2'd3) begin
                     state_in = S_OUT;
                  end
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               row_in   = row_ff + 2'd1;
               if (row_ff == ROW_LAST) begin
                  row_in   = 2'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (load_out || load_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         jcnt_ff      <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < JOINT_COUNT; j++) begin
            joint_ff[j] <= '0;
         end
         for (int r = 0; r < 4; r++) begin
            off_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         jcnt_ff      <= jcnt_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (joint_we) begin
            joint_ff[q_entry.joint] <= q_entry.angle;
         end
         if (csr_write_en) begin
            off_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Datapath registers, no reset.
   always_ff @(posedge clock) begin
      if (trig_we) begin
         sin_ff[jcnt_ff] <= s_val;
         cos_ff[jcnt_ff] <= c_val;
      end
      if (init_we) begin
         p_rot_ff[0][0] <= ROT_W'(1) <<< FRAC_BITS;
         p_rot_ff[0][1] <= '0;
         p_rot_ff[0][2] <= '0;
         p_rot_ff[1][0] <= '0;
         p_rot_ff[1][1] <= ROT_W'(cos_ff[0]);
         p_rot_ff[1][2] <= -ROT_W'(sin_ff[0]);
         p_rot_ff[2][0] <= '0;
         p_rot_ff[2][1] <= ROT_W'(sin_ff[0]);
         p_rot_ff[2][2] <= ROT_W'(cos_ff[0]);
         p_tr_ff[0]     <= TR_W'(off_ff[REG_BASE]);
         p_tr_ff[1]     <= '0;
         p_tr_ff[2]     <= '0;
      end
      if (state_ff == S_MUL) begin
         acc_ff <= acc_in;
         if (step_ff == 3'd2) begin
            r0_ff <= rnd[ROT_W-1:0];
         end
         if (step_ff == 3'd4) begin
            r2_ff <= rnd[ROT_W-1:0];
         end
      end
      if (row_we) begin
         p_rot_ff[row_ff][0] <= r0_ff;
         p_rot_ff[row_ff][1] <= a1;
         p_rot_ff[row_ff][2] <= r2_ff;
         p_tr_ff[row_ff]     <= tr_new;
      end
      if (load_out) begin
         status_ff  <= ST_OK;
         row_idx_ff <= row_ff;
         col_ff[0]  <= DATA_W'(p_rot_ff[row_ff][0]);
         col_ff[1]  <= DATA_W'(p_rot_ff[row_ff][1]);
         col_ff[2]  <= DATA_W'(p_rot_ff[row_ff][2]);
         col_ff[3]  <= sat32(p_tr_ff[row_ff]);
         last_ff    <= (row_ff == ROW_LAST);
      end else if (load_err) begin
         status_ff  <= q_entry.status;
         row_idx_ff <= 2'd0;
         for (int c = 0; c < 4; c++) begin
            col_ff[c] <= '0;
         end
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_row_index = row_idx_ff;
   assign rsp_elem_col0 = col_ff[0];
   assign rsp_elem_col1 = col_ff[1];
   assign rsp_elem_col2 = col_ff[2];
   assign rsp_elem_col3 = col_ff[3];
   assign rsp_last_row  = last_ff;

`ifndef SYNTH
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> last_ff && row_idx_ff == 2'd0)
      else $error("error result not a single last row");

   a_last_on_row2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_OK |-> last_ff == (row_idx_ff == ROW_LAST))
      else $error("last_row does not match row index");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE && q_valid)
      else $error("queue popped outside idle");

   a_mul_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> step_ff <= 3'd5 && jcnt_ff != 2'd0)
      else $error("multiply sequencer out of range");
`endif

endmodule

// File: rtl/joint_forward_kinematics.sv
// Top level of the joint forward-kinematics block.
// Instantiates jfk_front and jfk_back; depends on jfk_pkg.
//
// Each accepted joint update is checked and queued (two deep); a bad joint
// number or angle yields one result with a nonzero status once it reaches
// the head of the queue. A good update is stored and the base-to-tool
// transform rebuilt: dequeue, sine lookups for four joints, load of the
// first joint's rotation, then the multiply-accumulate steps on the single
// shared multiplier (three joints, three rows, six steps per row), then the
// three rows at one per cycle when the consumer keeps rsp_ready high.
// Offsets are written through csr_write_en/csr_index/csr_wdata; the user
// must write them only while the block is idle; the block does not enforce it.
module joint_forward_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [jfk_pkg::JN_W-1:0]          req_joint_number,
   input  logic signed [jfk_pkg::JA_W-1:0]   req_joint_angle,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [1:0]                        rsp_row_index,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col0,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col1,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col2,
   output logic signed [jfk_pkg::DATA_W-1:0] rsp_elem_col3,
   output logic                              rsp_last_row,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [jfk_pkg::DATA_W-1:0]        csr_wdata
);
   import jfk_pkg::*;

   logic     q_valid;
   logic     q_pop;
   qent_type q_entry;

   jfk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_joint_number (req_joint_number),
      .req_joint_angle  (req_joint_angle),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   jfk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_row_index (rsp_row_index),
      .rsp_elem_col0 (rsp_elem_col0),
      .rsp_elem_col1 (rsp_elem_col1),
      .rsp_elem_col2 (rsp_elem_col2),
      .rsp_elem_col3 (rsp_elem_col3),
      .rsp_last_row  (rsp_last_row)
   );

endmodule

// File: sim/tb_joint_forward_kinematics.sv
// Testbench for joint_forward_kinematics: joint updates in, transform rows out.
// Rows are predicted in-bench from the joint angles and offsets and checked in order.
// Depends on jfk_pkg and the joint_forward_kinematics RTL.
`timescale 1ns / 1ps

module tb_joint_forward_kinematics;
   import jfk_pkg::*;

   typedef longint mat_type [3][4];

   typedef struct {
      logic [JN_W-1:0]         joint;
      logic signed [JA_W-1:0]  angle;
   } update_type;

   typedef struct {
      status_type        status;
      logic [1:0]        row;
      logic [31:0]       col [4];
      logic              last;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [JN_W-1:0] req_joint_number = '0;
   logic signed [JA_W-1:0] req_joint_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [1:0] rsp_row_index;
   logic signed [DATA_W-1:0] rsp_elem_col0, rsp_elem_col1, rsp_elem_col2, rsp_elem_col3;
   logic rsp_last_row;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   joint_forward_kinematics DUT (.*);

   always #10 clock = ~clock;

   update_type pending_updates [$];
   row_type    expected_rows [$];
   longint  offsets [4];
   int      joint_deg [JOINT_COUNT];
   int      errors = 0;
   int      updates_taken = 0;
   bit      req_took = 1'b0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint sine_deg(input int d);
      longint unsigned x, x2, t, s30;
      x  = longint'(d) * 64'd18740330;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 7; k >= 1; k--)
         t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
      s30 = (x * t) >> 30;
      return longint'((s30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   endfunction

   task automatic sin_cos(input int deg, output longint s, output longint c);
      int m;
      m = deg < 0 ? -deg : deg;
      if (m <= QUARTER) begin
         s = sine_deg(m);
         c = sine_deg(QUARTER - m);
      end else begin
         s = sine_deg(HALF - m);
         c = -sine_deg(m - QUARTER);
      end
      if (deg < 0) s = -s;
   endtask

   task automatic joint_frame(input bit about_x, input int deg, input longint off,
                              output mat_type t);
      longint s, c;
      sin_cos(deg, s, c);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 4; j++) t[i][j] = 0;
      t[0][3] = off;
      if (about_x) begin
         t[0][0] = 64'sd1 << FRAC_BITS;
         t[1][1] = c; t[1][2] = -s;
         t[2][1] = s; t[2][2] = c;
      end else begin
         t[0][0] = c; t[0][2] = s;
         t[1][1] = 64'sd1 << FRAC_BITS;
         t[2][0] = -s; t[2][2] = c;
      end
   endtask

   task automatic chain(input mat_type a, input mat_type b, output mat_type r);
      longint acc, h;
      h = 64'sd1 << (FRAC_BITS - 1);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
            acc = acc >= 0 ? (acc + h) >>> FRAC_BITS : -((-acc + h) >>> FRAC_BITS);
            r[i][j] = acc + (j == 3 ? a[i][3] : 0);
         end
   endtask

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic predict_rows(input update_type u);
      row_type r;
      mat_type a, b, p, q;
      int ang;
      ang = int'(u.angle);
      r.row = '0;
      r.last = 1'b1;
      for (int j = 0; j < 4; j++) r.col[j] = '0;
      if (u.joint < 1 || u.joint > JOINT_COUNT) begin
         r.status = ST_BAD_JOINT;
         expected_rows.push_back(r);
      end else if (ang < ANGLE_MIN || ang > ANGLE_MAX) begin
         r.status = ST_BAD_ANGLE;
         expected_rows.push_back(r);
      end else begin
         joint_deg[u.joint - 1] = ang;
         joint_frame(1'b1, joint_deg[0], offsets[REG_BASE], a);
         joint_frame(1'b0, joint_deg[1], offsets[REG_SHOULDER], b);
         chain(a, b, p);
         joint_frame(1'b0, joint_deg[2], offsets[REG_ELBOW], b);
         chain(p, b, q);
         joint_frame(1'b0, -joint_deg[3], offsets[REG_TOOL], b);
         chain(q, b, p);
         r.status = ST_OK;
         for (int i = 0; i < 3; i++) begin
            r.row = 2'(i);
            r.last = (i == 2);
            for (int j = 0; j < 4; j++) r.col[j] = clamp32(p[i][j]);
            expected_rows.push_back(r);
         end
      end
   endtask

   // accept side: predict on every accepted update
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      if (req_took) begin
         update_type u;
         u.joint = req_joint_number;
         u.angle = req_joint_angle;
         predict_rows(u);
         updates_taken++;
      end
   end

   // driver: bursts of items with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      logic nv;
      update_type u;
      nv = req_valid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_took) nv = 1'b0;
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_updates.size() > 0) begin
               u = pending_updates.pop_front();
               req_joint_number <= u.joint;
               req_joint_angle <= u.angle;
               nv = 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
      end
      req_valid <= nv;
   end

   // receiver: own stall pattern plus one long hold-off
   int hold_left = 0;
   bit held_once = 1'b0;
   int stall_mode = 0;
   always @(negedge clock) begin
      if (!held_once && updates_taken >= 40) begin
         held_once = 1'b1;
         hold_left = 400;
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_ready <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      row_type e;
      logic [31:0] got [4];
      if (!reset && rsp_valid && rsp_ready) begin
         got[0] = rsp_elem_col0; got[1] = rsp_elem_col1;
         got[2] = rsp_elem_col2; got[3] = rsp_elem_col3;
         if (expected_rows.size() == 0) begin
            report("row with no pending update");
         end else begin
            e = expected_rows.pop_front();
            if (rsp_status !== e.status)
               report($sformatf("status %0d, want %0d", rsp_status, e.status));
            if (rsp_row_index !== e.row)
               report($sformatf("row_index %0d, want %0d", rsp_row_index, e.row));
            if (rsp_last_row !== e.last)
               report($sformatf("last_row %0b, want %0b", rsp_last_row, e.last));
            for (int j = 0; j < 4; j++)
               if (got[j] !== e.col[j])
                  report($sformatf("row %0d col %0d %h, want %h", e.row, j, got[j], e.col[j]));
         end
      end
   end

   task automatic set_offsets(input longint b, input longint s, input longint e,
                              input longint t);
      longint v [4];
      v = '{b, s, e, t};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index <= reg_idx_type'(i);
         csr_wdata <= v[i][31:0];
         offsets[i] = longint'(signed'(v[i][31:0]));
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_idle;
      while (pending_updates.size() > 0 || req_valid || expected_rows.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic queue_update(input int jn, input int ang);
      update_type u;
      u.joint = JN_W'(jn);
      u.angle = JA_W'(ang);
      pending_updates.push_back(u);
   endtask

   task automatic queue_random(input int n);
      int jn, ang, pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 19);
         jn = $urandom_range(1, 4);
         if ($urandom_range(0, 3) == 0) jn = $urandom_range(1, JOINT_COUNT);
         ang = $urandom_range(0, 360) - 180;
         if ($urandom_range(0, 7) == 0) ang = ($urandom_range(0, 1) ? 180 : -180);
         if (pick == 0) jn = ($urandom_range(0, 1) ? 0 : 7);
         if (pick == 1) ang = $urandom_range(0, 1023) - 512;
         if (pick == 2) ang = ($urandom_range(0, 1) ? $urandom_range(181, 511)
                                                     : -$urandom_range(181, 512));
         queue_update(jn, ang);
      end
   endtask

   initial begin
      for (int i = 0; i < 4; i++) offsets[i] = 0;
      for (int i = 0; i < JOINT_COUNT; i++) joint_deg[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_offsets(64'sd65536, 64'sd131072, -64'sd98304, 64'sd32768);
      // directed: field extremes, every status, joints beyond four
      queue_update(0, 0);
      queue_update(7, 45);
      queue_update(1, 181);
      queue_update(2, -181);
      queue_update(3, 511);
      queue_update(4, -512);
      queue_update(0, 511);
      queue_update(1, 180);
      queue_update(1, -180);
      queue_update(2, 90);
      queue_update(2, -90);
      queue_update(3, 1);
      queue_update(3, -1);
      queue_update(4, 135);
      queue_update(4, -135);
      queue_update(5, 77);
      queue_update(6, -180);
      queue_update(1, 0);
      queue_update(2, 45);
      queue_update(3, -60);
      wait_idle();
      set_offsets(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
      queue_random(40);
      wait_idle();
      set_offsets(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
      queue_random(35);
      wait_idle();
      set_offsets(0, 0, 0, 0);
      queue_random(35);
      wait_idle();
      set_offsets(longint'($urandom), longint'($urandom), 64'sd2147483647,
                  -64'sd2147483648);
      queue_random(40);
      wait_idle();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/jfk_pkg.sv
rtl/jfk_front.sv
rtl/jfk_back.sv
rtl/joint_forward_kinematics.sv
sim/tb_joint_forward_kinematics.sv
